// ===== rtl/max_pool_2d_argmax_defines.svh =====
// Assertion macros for the max pooling block and its checker.
// Needs a clk and an rst_n signal in the scope where a macro is used.
`ifndef MAX_POOL_2D_ARGMAX_DEFINES_SVH
`define MAX_POOL_2D_ARGMAX_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mpa_pkg.sv =====
// Shared types and constants of the max pooling block.
// No dependencies; the configuration, controller, datapath, top level and result interface import it.
package mpa_pkg;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 11;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SIZE   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_SIZE     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 3'd4;

    localparam int WINDOW_BITS  = 3;
    localparam int STEP_BITS    = 3;
    localparam int WIDTH_BITS   = 9;
    localparam int HEIGHT_BITS  = 9;
    localparam int CHAN_CNT_BITS = 11;

    localparam int RESET_WINDOW_SIZE   = 2;
    localparam int RESET_STEP_SIZE     = 2;
    localparam int RESET_FRAME_WIDTH   = 256;
    localparam int RESET_FRAME_HEIGHT  = 256;
    localparam int RESET_CHANNEL_COUNT = 1;

    localparam int MAX_CHANNELS = 1024;
    localparam int CHANNEL_BITS = 10;
    localparam int POS_BITS     = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // take the offered sample word
        logic scan_read;  // read the next window entry from the line store
        logic load_out;   // move the window result into the output register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic window_hit; // the current position completes a window
        logic scan_last;  // the read issued now is the last of the window
        logic out_free;   // the output register can take a result this cycle
    } dp_status_t;

endpackage

// ===== rtl/mpa_stream_ifs.sv =====
// Valid/ready stream interfaces for the sample and result channels.
// Depends on mpa_pkg for the result field widths.
interface mpa_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mpa_result_if #(
    parameter int SAMPLE_BITS = 16
);
    import mpa_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] pooled_value;
    logic [POS_BITS-1:0]           max_row;
    logic [POS_BITS-1:0]           max_col;
    logic [CHANNEL_BITS-1:0]       channel;
    logic                          last_of_plane;
    logic                          last_of_frame;

    modport source (output valid, output pooled_value, output max_row, output max_col,
                    output channel, output last_of_plane, output last_of_frame,
                    input ready);
    modport sink   (input valid, input pooled_value, input max_row, input max_col,
                    input channel, input last_of_plane, input last_of_frame,
                    output ready);
endinterface

// ===== rtl/mpa_cfg.sv =====
// Configuration registers of the max pooling block and their clamped values.
// Depends on mpa_pkg.
module mpa_cfg #(
    parameter int MAX_WINDOW = 4,
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                write_enable,
    input  logic [mpa_pkg::CFG_INDEX_BITS-1:0]  reg_index,
    input  logic [mpa_pkg::CFG_DATA_BITS-1:0]   write_data,
    output logic [$clog2(MAX_WINDOW+1)-1:0]     window_k,
    output logic [mpa_pkg::STEP_BITS-1:0]       step,
    output logic [$clog2(MAX_WIDTH+1)-1:0]      width,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]     height,
    output logic [mpa_pkg::CHAN_CNT_BITS-1:0]   channels,
    output logic                                restart,
    output logic [$clog2(MAX_WINDOW+1)-1:0]     restart_k
);
    import mpa_pkg::*;

    localparam int KW = $clog2(MAX_WINDOW + 1);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [WINDOW_BITS-1:0]   window_reg;
    logic [STEP_BITS-1:0]     step_reg;
    logic [WIDTH_BITS-1:0]    width_reg;
    logic [HEIGHT_BITS-1:0]   height_reg;
    logic [CHAN_CNT_BITS-1:0] channels_reg;

    // Zero acts as one, and anything above the maximum acts as the maximum.
    function automatic logic [31:0] clamp_range(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] r;
        if (v == 32'd0) begin
            r = 32'd1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            window_reg   <= WINDOW_BITS'(RESET_WINDOW_SIZE);
            step_reg     <= STEP_BITS'(RESET_STEP_SIZE);
            width_reg    <= WIDTH_BITS'(RESET_FRAME_WIDTH);
            height_reg   <= HEIGHT_BITS'(RESET_FRAME_HEIGHT);
            channels_reg <= CHAN_CNT_BITS'(RESET_CHANNEL_COUNT);
        end else if (write_enable) begin
            case (reg_index)
                REG_WINDOW_SIZE:   window_reg   <= write_data[WINDOW_BITS-1:0];
                REG_STEP_SIZE:     step_reg     <= write_data[STEP_BITS-1:0];
                REG_FRAME_WIDTH:   width_reg    <= write_data[WIDTH_BITS-1:0];
                REG_FRAME_HEIGHT:  height_reg   <= write_data[HEIGHT_BITS-1:0];
                REG_CHANNEL_COUNT: channels_reg <= write_data[CHAN_CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign window_k = KW'(clamp_range(32'(window_reg), 32'(MAX_WINDOW)));
    assign step     = (step_reg == '0) ? STEP_BITS'(1) : step_reg;
    assign width    = WW'(clamp_range(32'(width_reg), 32'(MAX_WIDTH)));
    assign height   = HW'(clamp_range(32'(height_reg), 32'(MAX_HEIGHT)));
    assign channels = CHAN_CNT_BITS'(clamp_range(32'(channels_reg), 32'(MAX_CHANNELS)));

    // A write to any known register restarts the frame; the window size that
    // holds after the write is needed at the same edge.
    assign restart   = write_enable && (reg_index <= REG_CHANNEL_COUNT);
    assign restart_k = (reg_index == REG_WINDOW_SIZE)
                     ? KW'(clamp_range(32'(write_data[WINDOW_BITS-1:0]), 32'(MAX_WINDOW)))
                     : window_k;

endmodule

// ===== rtl/mpa_ctrl.sv =====
// Controller of the max pooling block: sequences sample intake, window scan
// and result hand-off. Depends on mpa_pkg.
module mpa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mpa_pkg::dp_status_t status,
    output mpa_pkg::dp_cmd_t    cmd
);
    import mpa_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.accept    = 1'b0;
        cmd.scan_read = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && status.window_hit) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_read = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_FINISH;
                end
            end
            // The last entry read is compared in this cycle.
            ST_FINISH: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/mpa_dp.sv =====
// Datapath of the max pooling block: position counters, line store, window
// scan with running maximum, and the output register. Depends on mpa_pkg.
module mpa_dp #(
    parameter int MAX_WINDOW  = 4,
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mpa_pkg::dp_cmd_t                  cmd,
    output mpa_pkg::dp_status_t               status,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]   window_k,
    input  logic [mpa_pkg::STEP_BITS-1:0]     step,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   height,
    input  logic [mpa_pkg::CHAN_CNT_BITS-1:0] channels,
    input  logic                              restart,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]   restart_k,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic signed [SAMPLE_BITS-1:0]     pooled_value,
    output logic [mpa_pkg::POS_BITS-1:0]      max_row,
    output logic [mpa_pkg::POS_BITS-1:0]      max_col,
    output logic [mpa_pkg::CHANNEL_BITS-1:0]  channel,
    output logic                              last_of_plane,
    output logic                              last_of_frame
);
    import mpa_pkg::*;

    localparam int KW    = $clog2(MAX_WINDOW + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int EW    = $clog2(MAX_WIDTH + 16);
    localparam int FW    = $clog2(MAX_HEIGHT + 16);
    localparam int SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int TW    = $clog2(2 * MAX_WINDOW + 1);
    localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int K_RESET = (MAX_WINDOW < RESET_WINDOW_SIZE) ? MAX_WINDOW : RESET_WINDOW_SIZE;

    // Line store: one row of MAX_WIDTH entries per slot, slot = row mod MAX_WINDOW.
    logic signed [SAMPLE_BITS-1:0] line_mem [DEPTH];

    // Position of the next sample.
    logic [CW-1:0]           col_reg;
    logic [RW-1:0]           row_reg;
    logic [CHANNEL_BITS-1:0] ch_reg;
    logic [SW-1:0]           slot_reg;
    // Column and row at which the next window closes.
    logic [EW-1:0]           cend_reg;
    logic [FW-1:0]           rend_reg;

    // Window being scanned.
    logic [CW-1:0]           win_c0_reg;
    logic [RW-1:0]           win_r0_reg;
    logic [CHANNEL_BITS-1:0] win_ch_reg;
    logic                    win_lp_reg;
    logic                    win_lf_reg;
    logic [KW-1:0]           m_reg;
    logic [KW-1:0]           n_reg;
    logic [SW-1:0]           rd_slot_reg;

    // Read pipeline and running maximum.
    logic signed [SAMPLE_BITS-1:0] rdata_reg;
    logic                          pend_reg;
    logic [RW-1:0]                 pend_row_reg;
    logic [CW-1:0]                 pend_col_reg;
    logic                          first_reg;
    logic signed [SAMPLE_BITS-1:0] best_reg;
    logic [RW-1:0]                 best_row_reg;
    logic [CW-1:0]                 best_col_reg;

    logic                    out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_value_reg;
    logic [POS_BITS-1:0]     out_row_reg;
    logic [POS_BITS-1:0]     out_col_reg;
    logic [CHANNEL_BITS-1:0] out_ch_reg;
    logic                    out_lp_reg;
    logic                    out_lf_reg;

    logic [KW-1:0] k_m1;
    logic          col_last;
    logic          row_last;
    logic          chan_last;
    logic          col_hit;
    logic          row_hit;
    logic          plane_last_win;
    logic [TW-1:0] start_sum;
    logic [SW-1:0] start_slot;
    logic [CW-1:0] rd_col;
    logic [RW-1:0] rd_row;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign k_m1      = window_k - KW'(1);
    assign col_last  = (WW'(col_reg) == width - WW'(1));
    assign row_last  = (HW'(row_reg) == height - HW'(1));
    assign chan_last = (CHAN_CNT_BITS'(ch_reg) == channels - CHAN_CNT_BITS'(1));
    assign col_hit   = (cend_reg == EW'(col_reg));
    assign row_hit   = (rend_reg == FW'(row_reg));

    // The window is the last of its plane when no further origin fits
    // either across or down.
    assign plane_last_win = (cend_reg + EW'(step) >= EW'(width))
                         && (rend_reg + FW'(step) >= FW'(height));

    // Slot of the window's top row: (slot - (k - 1)) mod MAX_WINDOW.
    assign start_sum  = TW'(slot_reg) + TW'(MAX_WINDOW) - TW'(k_m1);
    assign start_slot = (start_sum >= TW'(MAX_WINDOW)) ? SW'(start_sum - TW'(MAX_WINDOW))
                                                       : SW'(start_sum);

    assign rd_col  = win_c0_reg + CW'(n_reg);
    assign rd_row  = win_r0_reg + RW'(m_reg);
    assign wr_addr = AW'(slot_reg * MAX_WIDTH + col_reg);
    assign rd_addr = AW'(rd_slot_reg * MAX_WIDTH + rd_col);

    assign status.window_hit = col_hit && row_hit;
    assign status.scan_last  = (m_reg == k_m1) && (n_reg == k_m1);
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk) begin
        if (cmd.accept) begin
            line_mem[wr_addr] <= sample;
        end
        if (cmd.scan_read) begin
            rdata_reg <= line_mem[rd_addr];
        end
    end

    // Position counters.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            col_reg  <= '0;
            row_reg  <= '0;
            ch_reg   <= '0;
            slot_reg <= '0;
            cend_reg <= EW'(K_RESET - 1);
            rend_reg <= FW'(K_RESET - 1);
        end else if (restart) begin
            col_reg  <= '0;
            row_reg  <= '0;
            ch_reg   <= '0;
            slot_reg <= '0;
            cend_reg <= EW'(restart_k - KW'(1));
            rend_reg <= FW'(restart_k - KW'(1));
        end else if (cmd.accept) begin
            if (col_last) begin
                col_reg  <= '0;
                cend_reg <= EW'(k_m1);
                if (row_last) begin
                    row_reg  <= '0;
                    slot_reg <= '0;
                    rend_reg <= FW'(k_m1);
                    ch_reg   <= chan_last ? '0 : ch_reg + CHANNEL_BITS'(1);
                end else begin
                    row_reg  <= row_reg + RW'(1);
                    slot_reg <= (slot_reg == SW'(MAX_WINDOW - 1)) ? '0 : slot_reg + SW'(1);
                    if (row_hit) begin
                        rend_reg <= rend_reg + FW'(step);
                    end
                end
            end else begin
                col_reg <= col_reg + CW'(1);
                if (col_hit) begin
                    cend_reg <= cend_reg + EW'(step);
                end
            end
        end
    end

    // Window capture and scan address generation.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_reg       <= '0;
            n_reg       <= '0;
            rd_slot_reg <= '0;
            pend_reg    <= 1'b0;
            first_reg   <= 1'b0;
        end else begin
            pend_reg <= cmd.scan_read;
            if (cmd.accept && status.window_hit) begin
                m_reg       <= '0;
                n_reg       <= '0;
                rd_slot_reg <= start_slot;
                first_reg   <= 1'b1;
            end else begin
                if (cmd.scan_read) begin
                    if (n_reg == k_m1) begin
                        n_reg       <= '0;
                        m_reg       <= m_reg + KW'(1);
                        rd_slot_reg <= (rd_slot_reg == SW'(MAX_WINDOW - 1))
                                     ? '0 : rd_slot_reg + SW'(1);
                    end else begin
                        n_reg <= n_reg + KW'(1);
                    end
                end
                if (pend_reg) begin
                    first_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.accept && status.window_hit) begin
            win_c0_reg <= col_reg - CW'(k_m1);
            win_r0_reg <= row_reg - RW'(k_m1);
            win_ch_reg <= ch_reg;
            win_lp_reg <= plane_last_win;
            win_lf_reg <= plane_last_win && chan_last;
        end
        if (cmd.scan_read) begin
            pend_row_reg <= rd_row;
            pend_col_reg <= rd_col;
        end
        // Strict greater-than keeps the first position in raster order on a tie.
        if (pend_reg && (first_reg || (rdata_reg > best_reg))) begin
            best_reg     <= rdata_reg;
            best_row_reg <= pend_row_reg;
            best_col_reg <= pend_col_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load_out) begin
            out_value_reg <= best_reg;
            out_row_reg   <= POS_BITS'(best_row_reg);
            out_col_reg   <= POS_BITS'(best_col_reg);
            out_ch_reg    <= win_ch_reg;
            out_lp_reg    <= win_lp_reg;
            out_lf_reg    <= win_lf_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pooled_value  = out_value_reg;
    assign max_row       = out_row_reg;
    assign max_col       = out_col_reg;
    assign channel       = out_ch_reg;
    assign last_of_plane = out_lp_reg;
    assign last_of_frame = out_lf_reg;

endmodule

// ===== rtl/max_pool_2d_argmax.sv =====
// Streaming 2-D max pooling with argmax: top level joining the configuration
// registers, the controller and the datapath. Depends on mpa_pkg and the
// stream interfaces mpa_sample_if and mpa_result_if.
//
// Samples enter in raster order, one channel plane after another, and the last
// MAX_WINDOW rows are held in a single-port-read line store. A sample that
// does not complete a window leaves the input ready, so such words stream at
// one per clock. A sample that completes a k by k window is taken, the window
// is read out of the line store one entry per cycle, the last entry is
// compared and the output register is loaded; the input is not ready during
// the read, compare and load, and it waits longer only while a previous result
// still sits unread in the output register. The line store needs no clearing
// after reset. A configuration write restarts the frame.
module max_pool_2d_argmax #(
    parameter int MAX_WINDOW  = 4,
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               write_enable,
    input  logic [mpa_pkg::CFG_INDEX_BITS-1:0] reg_index,
    input  logic [mpa_pkg::CFG_DATA_BITS-1:0]  write_data,
    mpa_sample_if.sink                         samples,
    mpa_result_if.source                       results
);
    import mpa_pkg::*;

    localparam int KW = $clog2(MAX_WINDOW + 1);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [KW-1:0]            window_k;
    logic [STEP_BITS-1:0]     step;
    logic [WW-1:0]            width;
    logic [HW-1:0]            height;
    logic [CHAN_CNT_BITS-1:0] channels;
    logic                     restart;
    logic [KW-1:0]            restart_k;
    dp_cmd_t                  cmd;
    dp_status_t               status;

    mpa_cfg #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .window_k     (window_k),
        .step         (step),
        .width        (width),
        .height       (height),
        .channels     (channels),
        .restart      (restart),
        .restart_k    (restart_k)
    );

    mpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    mpa_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .sample        (samples.sample),
        .window_k      (window_k),
        .step          (step),
        .width         (width),
        .height        (height),
        .channels      (channels),
        .restart       (restart),
        .restart_k     (restart_k),
        .out_ready     (results.ready),
        .out_valid     (results.valid),
        .pooled_value  (results.pooled_value),
        .max_row       (results.max_row),
        .max_col       (results.max_col),
        .channel       (results.channel),
        .last_of_plane (results.last_of_plane),
        .last_of_frame (results.last_of_frame)
    );

endmodule

// ===== rtl/mpa_checker.sv =====
// Port-level checks for max_pool_2d_argmax, bound to the top level.
// Depends on max_pool_2d_argmax_defines.svh for the assertion macros.
`include "max_pool_2d_argmax_defines.svh"

module mpa_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] pooled_value,
    input logic                   last_of_plane,
    input logic                   last_of_frame
);

    // Intake stops only because a word just taken closed a window.
    `MPA_ASSERT_SAME(a_stall_after_accept, $fell(in_ready), $past(in_valid && in_ready), "input stalled without a preceding accept")

    // A window scan keeps the input stalled longer than the cycle in which ready falls.
    `MPA_ASSERT_NEXT(a_scan_holds_input, $fell(in_ready), !in_ready, "input ready returned before the window scan ended")

    // A new result is loaded only at the end of a scan, while intake is stalled.
    `MPA_ASSERT_SAME(a_result_after_scan, $rose(out_valid), $past(!in_ready), "result appeared without a window scan")

    // The end of a frame is always the end of a plane.
    `MPA_ASSERT_SAME(a_frame_end_in_plane, out_valid && last_of_frame, last_of_plane, "last_of_frame without last_of_plane")

    // A result waiting for the sink holds its value.
    `MPA_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(pooled_value), "stalled result changed")

endmodule

bind max_pool_2d_argmax mpa_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (samples.valid),
    .in_ready      (samples.ready),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .pooled_value  (results.pooled_value),
    .last_of_plane (results.last_of_plane),
    .last_of_frame (results.last_of_frame)
);
